FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/bcas_pkg.sv
// ----------------------------------------------------------------------------
// bcas_pkg
// shared constants, tables and command/status types of the angle stats block
// ----------------------------------------------------------------------------
package bcas_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int COORD_BITS  = 24;
   localparam int BONE_BITS   = COORD_BITS + 1;
   localparam int CNT_BITS    = $clog2(MAX_POINTS + 2);
   localparam int ANG_DEPTH   = MAX_POINTS - 2;
   localparam int IDX_BITS    = (ANG_DEPTH > 1) ? $clog2(ANG_DEPTH) : 1;
   localparam int ANGLE_BITS  = 15;
   localparam int SC_BITS     = 15;
   localparam int PROD_BITS   = 2 * SC_BITS;
   localparam int DOT_BITS    = PROD_BITS + 2;
   localparam int SQ_BITS     = 2 * DOT_BITS;
   localparam int ROOT_BITS   = DOT_BITS;
   localparam int CORDIC_BITS = DOT_BITS + 16 + 3;
   localparam int Z_BITS      = 24;
   localparam int STEPS       = 20;

   localparam logic [ANGLE_BITS-1:0] ANGLE_PI   = 15'd25736;
   localparam logic [Z_BITS-1:0]     PI_Q20     = 24'd3294199;
   localparam logic [Z_BITS-1:0]     HALF_PI_Q20 = 24'd1647099;

   typedef logic signed [BONE_BITS-1:0] bone_type [3];

   function automatic logic [Z_BITS-1:0] atan_q20(input logic [4:0] i);
      logic [Z_BITS-1:0] t;
      case (i)
         5'd0: t = 24'd823550;
         5'd1: t = 24'd486170;
         5'd2: t = 24'd256879;
         5'd3: t = 24'd130396;
         5'd4: t = 24'd65451;
         5'd5: t = 24'd32757;
         5'd6: t = 24'd16383;
         5'd7: t = 24'd8192;
         5'd8: t = 24'd4096;
         5'd9: t = 24'd2048;
         5'd10: t = 24'd1024;
         5'd11: t = 24'd512;
         5'd12: t = 24'd256;
         5'd13: t = 24'd128;
         5'd14: t = 24'd64;
         5'd15: t = 24'd32;
         5'd16: t = 24'd16;
         5'd17: t = 24'd8;
         5'd18: t = 24'd4;
         5'd19: t = 24'd2;
         default: t = '0;
      endcase
      return t;
   endfunction

   typedef struct packed {
      logic load;       // latch the transaction
      logic scale;      // form the bone
      logic mul;        // step products, selector in mul_sel
      logic [2:0] mul_sel;
      logic sum;        // normalize both bones
      logic root_start;
      logic cordic_init;
      logic cordic_step;
      logic finish;     // fold angle into stats, start insert
      logic ins_step;
      logic commit;     // update prev state
      logic respond;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic       need_angle;
      logic       any_zero;
      logic       root_done;
      logic       cordic_done;
      logic       ins_done;
      logic       last;
   } status_type;

endpackage

FILE: hw/rtl/bcas_datapath.sv
// ----------------------------------------------------------------------------
// bcas_datapath
// bone forming, scaling, products, square root, cordic and sorted store
// ----------------------------------------------------------------------------
module bcas_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bcas_pkg::cmd_type                   cmd,
   output bcas_pkg::status_type                sts,
   input  logic signed [bcas_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [bcas_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic signed [bcas_pkg::COORD_BITS-1:0] req_pos_z,
   input  logic                                req_last_point,
   output logic                                rsp_chain_valid,
   output logic [bcas_pkg::ANGLE_BITS-1:0]     rsp_min_angle,
   output logic [bcas_pkg::ANGLE_BITS-1:0]     rsp_max_angle,
   output logic [bcas_pkg::ANGLE_BITS-1:0]     rsp_median_angle,
   output logic                                rsp_degenerate_bone,
   output logic                                rsp_too_long
);
   localparam int CB = bcas_pkg::COORD_BITS;
   localparam int BB = bcas_pkg::BONE_BITS;
   localparam int SB = bcas_pkg::SC_BITS;
   localparam int PB = bcas_pkg::PROD_BITS;
   localparam int DB = bcas_pkg::DOT_BITS;
   localparam int QB = bcas_pkg::SQ_BITS;
   localparam int RB = bcas_pkg::ROOT_BITS;
   localparam int XB = bcas_pkg::CORDIC_BITS;
   localparam int ZB = bcas_pkg::Z_BITS;
   localparam int AB = bcas_pkg::ANGLE_BITS;
   localparam int NB = bcas_pkg::CNT_BITS;
   localparam int IB = bcas_pkg::IDX_BITS;
   localparam int MB = BB + 1;

   logic signed [CB-1:0] prev_pt_ff [3];
   logic signed [CB-1:0] cur_pt_ff [3];
   logic signed [BB-1:0] prev_bone_ff [3];
   logic signed [BB-1:0] bone_ff [3];
   logic signed [SB-1:0] sa_ff [3];
   logic signed [SB-1:0] sb_ff [3];
   logic signed [PB-1:0] prod_ff [9];
   logic signed [DB-1:0] dot_ff;
   logic [QB-1:0]        sq_ff;
   logic [NB-1:0]        count_ff;
   logic                 last_ff;
   logic                 degen_ff;
   logic [AB-1:0]        min_ff;
   logic [AB-1:0]        max_ff;
   logic [AB-1:0]        ang_ff;
   logic [AB-1:0]        store [bcas_pkg::ANG_DEPTH];
   logic [IB:0]          k_ff;
   logic [AB-1:0]        rd_ff;
   logic                 rd_ok_ff;
   logic                 ins_done_ff;

   // square root, one result bit per cycle
   logic [RB:0]   rem_ff;
   logic [RB-1:0] root_ff;
   logic [$clog2(RB+1)-1:0] rcnt_ff;
   logic          rbusy_ff;

   // cordic
   logic signed [XB-1:0] cx_ff, cy_ff;
   logic signed [ZB+1:0] cz_ff;
   logic [4:0]           step_ff;

   function automatic logic [SB-1:0] mag_scale(input logic [MB-1:0] m,
                                               input logic [MB-1:0] mmax);
      logic [MB-1:0] v;
      v = m;
      for (int s = MB - 1; s >= 14; s--) begin
         if (mmax >= (MB'(1) << s)) begin
            v = m >> (s - 13);
            return SB'(v);
         end
      end
      for (int s = 13; s >= 0; s--) begin
         if (mmax >= (MB'(1) << s)) begin
            v = m << (13 - s);
            return SB'(v);
         end
      end
      return SB'(v);
   endfunction

   function automatic logic [MB-1:0] absv(input logic signed [BB-1:0] v);
      logic signed [MB-1:0] e;
      e = MB'(v);
      return (e < 0) ? MB'(-e) : MB'(e);
   endfunction

   function automatic void scale3(input logic signed [BB-1:0] v [3],
                                  output logic signed [SB-1:0] o [3]);
      logic [MB-1:0] m [3];
      logic [MB-1:0] mx;
      logic [SB-1:0] q;
      for (int i = 0; i < 3; i++) m[i] = absv(v[i]);
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      for (int i = 0; i < 3; i++) begin
         q = mag_scale(m[i], mx);
         o[i] = v[i][BB-1] ? -$signed(q) : $signed(q);
      end
   endfunction

   logic signed [SB-1:0] sa_in [3], sb_in [3];
   logic signed [BB-1:0] nb [3];
   always_comb begin
      scale3(prev_bone_ff, sa_in);
      scale3(bone_ff, sb_in);
      for (int i = 0; i < 3; i++) nb[i] = BB'(cur_pt_ff[i]) - BB'(prev_pt_ff[i]);
   end

   // one multiplier operand pair per mul_sel
   logic signed [SB-1:0] ma, mb;
   always_comb begin
      case (cmd.mul_sel)
         3'd0: begin ma = sa_ff[0]; mb = sb_ff[0]; end
         3'd1: begin ma = sa_ff[1]; mb = sb_ff[1]; end
         3'd2: begin ma = sa_ff[2]; mb = sb_ff[2]; end
         3'd3: begin ma = sa_ff[1]; mb = sb_ff[2]; end
         3'd4: begin ma = sa_ff[2]; mb = sb_ff[1]; end
         3'd5: begin ma = sa_ff[2]; mb = sb_ff[0]; end
         3'd6: begin ma = sa_ff[0]; mb = sb_ff[2]; end
         default: begin ma = sa_ff[0]; mb = sb_ff[1]; end
      endcase
   end
   logic signed [PB-1:0] prod7_ff;
   logic signed [PB-1:0] prod8_ff;

   logic signed [DB-1:0] crx, cry, crz;
   logic signed [DB-1:0] dot_in;
   always_comb begin
      dot_in = DB'(prod_ff[0]) + DB'(prod_ff[1]) + DB'(prod_ff[2]);
      crx = DB'(prod_ff[3]) - DB'(prod_ff[4]);
      cry = DB'(prod_ff[5]) - DB'(prod_ff[6]);
      crz = DB'(prod7_ff) - DB'(prod8_ff);
   end

   // sum of the squares of the cross components
   logic [QB-1:0] sq_in;
   always_comb begin
      sq_in = QB'(crx * crx) + QB'(cry * cry) + QB'(crz * crz);
   end

   // digit by digit root, two radicand bits per cycle
   logic [RB+2:0] rem_sh;
   logic [RB+2:0] trial;
   always_comb begin
      rem_sh = {rem_ff, sq_ff[QB-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
   end

   logic signed [XB-1:0] dxs, dys;
   always_comb begin
      dxs = cy_ff >>> step_ff;
      dys = cx_ff >>> step_ff;
   end

   logic signed [ZB+1:0] zc;
   logic [ZB-1:0] zr;
   logic [ZB-1:0] tz;
   always_comb begin
      zc = cz_ff;
      if (zc < 0) zc = '0;
      if (zc > $signed({2'b00, bcas_pkg::PI_Q20})) zc = $signed({2'b00, bcas_pkg::PI_Q20});
      tz = ZB'(zc) + ZB'(64);
      zr = tz >> 7;
   end
   logic [AB-1:0] ang_fin;
   always_comb ang_fin = (zr > ZB'(bcas_pkg::ANGLE_PI)) ? bcas_pkg::ANGLE_PI : AB'(zr);

   logic [NB-1:0] n_pts;
   logic [IB:0]   med_idx;
   always_comb begin
      n_pts = (count_ff > NB'(bcas_pkg::MAX_POINTS)) ? NB'(bcas_pkg::MAX_POINTS) : count_ff;
      med_idx = (IB+1)'((n_pts - NB'(3)) >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         degen_ff <= 1'b0;
         min_ff   <= bcas_pkg::ANGLE_PI;
         max_ff   <= '0;
         rbusy_ff <= 1'b0;
         ins_done_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_pt_ff[i]   <= '0;
            prev_bone_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            cur_pt_ff[0] <= req_pos_x;
            cur_pt_ff[1] <= req_pos_y;
            cur_pt_ff[2] <= req_pos_z;
            last_ff      <= req_last_point;
         end
         if (cmd.scale) begin
            for (int i = 0; i < 3; i++) begin
               bone_ff[i] <= nb[i];
            end
            if (count_ff >= NB'(1) && count_ff < NB'(bcas_pkg::MAX_POINTS)
                && nb[0] == 0 && nb[1] == 0 && nb[2] == 0) degen_ff <= 1'b1;
         end
         if (cmd.mul_sel == 3'd7 && cmd.sum) begin
            sa_ff <= sa_in;
            sb_ff <= sb_in;
         end
         if (cmd.mul) begin
            case (cmd.mul_sel)
               3'd7: prod7_ff <= ma * mb;
               default: prod_ff[cmd.mul_sel] <= ma * mb;
            endcase
            if (cmd.mul_sel == 3'd7) prod8_ff <= sa_ff[1] * sb_ff[0];
         end
         if (cmd.root_start) begin
            dot_ff   <= dot_in;
            sq_ff    <= sq_in;
            rem_ff   <= '0;
            root_ff  <= '0;
            rcnt_ff  <= '0;
            rbusy_ff <= 1'b1;
         end else if (rbusy_ff) begin
            if (rem_sh >= trial) begin
               rem_ff  <= (RB+1)'(rem_sh - trial);
               root_ff <= {root_ff[RB-2:0], 1'b1};
            end else begin
               rem_ff  <= (RB+1)'(rem_sh);
               root_ff <= {root_ff[RB-2:0], 1'b0};
            end
            sq_ff <= sq_ff << 2;
            if (rcnt_ff == ($clog2(RB+1))'(RB - 1)) rbusy_ff <= 1'b0;
            rcnt_ff <= rcnt_ff + 1'b1;
         end
         if (cmd.cordic_init) begin
            step_ff <= '0;
            if (dot_ff < 0) begin
               cx_ff <= XB'($signed({1'b0, root_ff})) <<< 16;
               cy_ff <= XB'(-dot_ff) <<< 16;
               cz_ff <= $signed({2'b00, bcas_pkg::HALF_PI_Q20});
            end else begin
               cx_ff <= XB'(dot_ff) <<< 16;
               cy_ff <= XB'($signed({1'b0, root_ff})) <<< 16;
               cz_ff <= '0;
            end
         end
         if (cmd.cordic_step) begin
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + dxs;
               cy_ff <= cy_ff - dys;
               cz_ff <= cz_ff + $signed({2'b00, bcas_pkg::atan_q20(step_ff)});
            end else begin
               cx_ff <= cx_ff - dxs;
               cy_ff <= cy_ff + dys;
               cz_ff <= cz_ff - $signed({2'b00, bcas_pkg::atan_q20(step_ff)});
            end
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.finish) begin
            ang_ff <= sts.any_zero ? '0 : ang_fin;
            k_ff   <= (IB+1)'(count_ff - NB'(2));
            rd_ok_ff <= 1'b0;
            ins_done_ff <= 1'b0;
            if ((sts.any_zero ? '0 : ang_fin) < min_ff) min_ff <= sts.any_zero ? '0 : ang_fin;
            if ((sts.any_zero ? '0 : ang_fin) > max_ff) max_ff <= sts.any_zero ? '0 : ang_fin;
         end
         if (cmd.ins_step) begin
            if (!rd_ok_ff) begin
               if (k_ff == '0) begin
                  store[0] <= ang_ff;
                  ins_done_ff <= 1'b1;
               end else begin
                  rd_ff    <= store[IB'(k_ff - 1'b1)];
                  rd_ok_ff <= 1'b1;
               end
            end else begin
               rd_ok_ff <= 1'b0;
               if (rd_ff > ang_ff) begin
                  store[IB'(k_ff)] <= rd_ff;
                  k_ff <= k_ff - 1'b1;
               end else begin
                  store[IB'(k_ff)] <= ang_ff;
                  ins_done_ff <= 1'b1;
               end
            end
         end
         if (cmd.commit) begin
            ins_done_ff <= 1'b0;
            if (count_ff >= NB'(bcas_pkg::MAX_POINTS)) begin
               count_ff <= NB'(bcas_pkg::MAX_POINTS + 1);
            end else begin
               if (count_ff >= NB'(1)) prev_bone_ff <= bone_ff;
               prev_pt_ff <= cur_pt_ff;
               count_ff   <= count_ff + 1'b1;
            end
         end
         if (cmd.respond) begin
            rsp_chain_valid     <= n_pts >= NB'(3);
            rsp_min_angle       <= (n_pts >= NB'(3)) ? min_ff : '0;
            rsp_max_angle       <= (n_pts >= NB'(3)) ? max_ff : '0;
            rsp_median_angle    <= (n_pts >= NB'(3)) ? store[IB'(med_idx)] : '0;
            rsp_degenerate_bone <= degen_ff;
            rsp_too_long        <= count_ff > NB'(bcas_pkg::MAX_POINTS);
         end
      end
   end

   always_comb begin
      sts.need_angle  = count_ff >= NB'(2) && count_ff < NB'(bcas_pkg::MAX_POINTS);
      sts.any_zero    = (prev_bone_ff[0] == 0 && prev_bone_ff[1] == 0 && prev_bone_ff[2] == 0)
                        || (bone_ff[0] == 0 && bone_ff[1] == 0 && bone_ff[2] == 0);
      sts.root_done   = !rbusy_ff && !cmd.root_start;
      sts.cordic_done = step_ff == 5'(bcas_pkg::STEPS - 1);
      sts.ins_done    = ins_done_ff;
      sts.last        = last_ff;
   end

endmodule

FILE: hw/rtl/bcas_ctrl.sv
// ----------------------------------------------------------------------------
// bcas_ctrl
// sequencer for one point transaction and the result handshake
// ----------------------------------------------------------------------------
module bcas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bcas_pkg::status_type sts,
   output bcas_pkg::cmd_type    cmd
);
   typedef enum logic [3:0] {
      IDLE, BONE, SCALE, MUL, ROOT, CINIT, CSTEP, FIN, INS, COMMIT, RESP, HOLD
   } state_type;

   state_type state_ff;
   logic [2:0] sel_ff;
   logic       rsp_valid_ff;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.mul_sel = sel_ff;
      case (state_ff)
         IDLE:   cmd.load = req_valid;
         BONE:   cmd.scale = 1'b1;
         SCALE:  begin cmd.sum = 1'b1; cmd.mul_sel = 3'd7; end
         MUL:    cmd.mul = 1'b1;
         ROOT:   ;
         CINIT:  cmd.cordic_init = 1'b1;
         CSTEP:  cmd.cordic_step = 1'b1;
         FIN:    cmd.finish = 1'b1;
         INS:    cmd.ins_step = 1'b1;
         COMMIT: cmd.commit = 1'b1;
         RESP:   cmd.respond = 1'b1;
         HOLD:   cmd.clear = !rsp_stall;
         default: ;
      endcase
      if (state_ff == MUL && sel_ff == 3'd7) cmd.root_start = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: if (req_valid) state_ff <= BONE;
            BONE: state_ff <= sts.need_angle ? SCALE : COMMIT;
            SCALE: begin
               sel_ff   <= '0;
               state_ff <= MUL;
            end
            MUL: begin
               sel_ff <= sel_ff + 1'b1;
               if (sel_ff == 3'd7) state_ff <= ROOT;
            end
            ROOT: state_ff <= CINIT;
            CINIT: if (sts.root_done) state_ff <= CSTEP;
            CSTEP: if (sts.cordic_done) state_ff <= FIN;
            FIN: state_ff <= INS;
            INS: if (sts.ins_done) state_ff <= COMMIT;
            COMMIT: state_ff <= sts.last ? RESP : IDLE;
            RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= HOLD;
            end
            HOLD: if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/bcas_root_gate.sv
// ----------------------------------------------------------------------------
// bcas_root_gate
// issues the square root start once the products are settled
// ----------------------------------------------------------------------------
module bcas_root_gate (
   input  logic              clock,
   input  logic              reset,
   input  bcas_pkg::cmd_type cmd_in,
   output bcas_pkg::cmd_type cmd_out
);
   logic armed_ff;

   always_ff @(posedge clock) begin
      if (reset) armed_ff <= 1'b0;
      else armed_ff <= cmd_in.mul && cmd_in.mul_sel == 3'd7;
   end

   always_comb begin
      cmd_out = cmd_in;
      cmd_out.root_start = armed_ff;
   end

endmodule

FILE: hw/rtl/bone_chain_angle_stats.sv
// ----------------------------------------------------------------------------
// bone_chain_angle_stats
// bending angle min, max and median along a joint chain
// ----------------------------------------------------------------------------
// req_ carries one joint per transaction in chain order, req_last_point on the
// final joint. req_stall stays high while a joint is processed. The first two
// joints of a chain, and joints past the store capacity, go from bone forming
// straight to the commit and back to ready. Each later joint passes through
// bone forming and scaling, nine products on one multiplier with a second one
// for the last product, the sums, a bit-serial square root, a cordic load and
// 20 cordic steps, the fold of the angle into the statistics, insertion into
// the sorted store (a read and a write per moved entry), commit and ready.
// On the last joint one rsp_ transaction follows with min, max and lower
// median, rsp_valid rising after the respond state that follows the commit.
// rsp_valid holds with its payload while rsp_stall is high; no new joint is
// taken until the result is delivered, after which the chain state returns to
// its reset values. Reset is synchronous and clears all control and
// statistics state; the sorted store needs no clearing since only entries
// written in the current chain are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bone_chain_angle_stats (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [bcas_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [bcas_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic signed [bcas_pkg::COORD_BITS-1:0] req_pos_z,
   input  logic                                   req_last_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_chain_valid,
   output logic [bcas_pkg::ANGLE_BITS-1:0]        rsp_min_angle,
   output logic [bcas_pkg::ANGLE_BITS-1:0]        rsp_max_angle,
   output logic [bcas_pkg::ANGLE_BITS-1:0]        rsp_median_angle,
   output logic                                   rsp_degenerate_bone,
   output logic                                   rsp_too_long
);
   bcas_pkg::cmd_type    cmd_raw, cmd;
   bcas_pkg::status_type sts;

   bcas_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd(cmd_raw)
   );

   bcas_root_gate u_gate (
      .clock, .reset, .cmd_in(cmd_raw), .cmd_out(cmd)
   );

   bcas_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .req_pos_x, .req_pos_y, .req_pos_z, .req_last_point,
      .rsp_chain_valid, .rsp_min_angle, .rsp_max_angle, .rsp_median_angle,
      .rsp_degenerate_bone, .rsp_too_long
   );

   `ASSERT_CLK(a_rsp_blocks_req, clock, reset, rsp_valid |-> req_stall, "req taken during rsp")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "rsp dropped")
   `ASSERT_CLK(a_min_le_max, clock, reset, (rsp_valid && rsp_chain_valid) |-> (rsp_min_angle <= rsp_max_angle), "min above max")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp after reset")

endmodule
